// ===== design/hashed_ngram_byte_predictor_assert.svh =====
// assertion macros for the predictor rtl
`ifndef HASHED_NGRAM_BYTE_PREDICTOR_ASSERT_SVH
`define HASHED_NGRAM_BYTE_PREDICTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HNBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hnbp assertion failed");

// next-cycle implication, checked out of reset
`define HNBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hnbp assertion failed");

`endif

// ===== design/hnbp_pkg.sv =====
// shared constants and types of the byte predictor
`default_nettype none
package hnbp_pkg;
  localparam int MAX_ORDER     = 6;
  localparam int TABLE_ENTRIES = 65536;
  localparam int HASH_W        = $clog2(TABLE_ENTRIES);
  localparam int HIST_W        = 8 * MAX_ORDER;
  localparam int ORDER_W       = 3;
  localparam int CONF_W        = 16;
  localparam int ENTRY_W       = 8 + CONF_W;
  localparam int COUNT_W       = 31;
  localparam int ISSUE_DEPTH   = 4;
  localparam int RESULT_DEPTH  = 2;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [HASH_W-1:0] FNV_BASIS_H = FNV_BASIS[HASH_W-1:0];
  localparam logic [HASH_W-1:0] FNV_PRIME_H = FNV_PRIME[HASH_W-1:0];

  localparam logic [1:0] CMD_TRAIN   = 2'd0;
  localparam logic [1:0] CMD_CONTEXT = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0]                          cmd;
    logic [7:0]                          data_byte;
    logic [ORDER_W-1:0]                  fill;
    logic [MAX_ORDER-1:0][HASH_W-1:0]    hash;
  } issue_t;

  typedef struct packed {
    logic [7:0]         predicted_byte;
    logic [7:0]         confidence;
    logic [ORDER_W-1:0] best_order;
    logic [COUNT_W-1:0] trained_total;
  } result_t;
endpackage
`default_nettype wire

// ===== design/hnbp_front.sv =====
// front end: history, context hashes and the issue queue
`default_nettype none
module hnbp_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire logic [1:0]      cmd,
  input  wire logic [7:0]      data_byte,
  input  wire logic            restart,
  output logic                 full,
  input  wire logic            clearing,
  input  wire logic            iq_pop,
  output logic                 iq_empty,
  output hnbp_pkg::issue_t     iq_head
);
  import hnbp_pkg::*;

  localparam int PTR_W = $clog2(ISSUE_DEPTH);

  // running fnv-1a hash of the last b+1 bytes sits at index b
  logic [MAX_ORDER-1:0][HASH_W-1:0] hreg;
  logic [MAX_ORDER-1:0][HASH_W-1:0] hash_cur;
  logic [MAX_ORDER-1:0][HASH_W-1:0] hash_next;
  logic [HASH_W-1:0]  hash_prev;
  logic [ORDER_W-1:0] fill;
  logic [ORDER_W-1:0] fill_cur;
  logic               accept;
  logic               enq;
  issue_t             entry;
  issue_t             queue [ISSUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign full     = (count == (PTR_W+1)'(ISSUE_DEPTH)) || clearing;
  assign iq_empty = (count == '0);
  assign iq_head  = queue[rd_ptr];
  assign accept   = push && !full;
  assign enq      = accept && (cmd != CMD_UNUSED);

  // restart empties history before the item looks at it
  assign hash_cur = restart ? {MAX_ORDER{FNV_BASIS_H}} : hreg;
  assign fill_cur = restart ? '0 : fill;

  // new byte extends each order by one step of the next lower order's hash
  always_comb begin
    hash_prev = FNV_BASIS_H;
    for (int b = 0; b < MAX_ORDER; b++) begin
      hash_next[b] = HASH_W'((hash_prev ^ HASH_W'(data_byte)) * FNV_PRIME_H);
      hash_prev    = hash_cur[b];
    end
  end

  always_comb begin
    entry.cmd       = cmd;
    entry.data_byte = data_byte;
    entry.fill      = fill_cur;
    entry.hash      = hash_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hreg <= {MAX_ORDER{FNV_BASIS_H}};
      fill <= '0;
    end else if (accept) begin
      if (cmd == CMD_TRAIN || cmd == CMD_CONTEXT) begin
        hreg <= hash_next;
        fill <= (fill_cur == ORDER_W'(MAX_ORDER)) ? fill_cur : fill_cur + 1'b1;
      end else begin
        hreg <= hash_cur;
        fill <= fill_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (iq_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (enq && !iq_pop) begin
        count <= count + 1'b1;
      end else if (iq_pop && !enq) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/hnbp_back.sv =====
// back end: table banks, clearing pass, train and query execution
`default_nettype none
module hnbp_back (
  input  wire logic            clk,
  input  wire logic            rst,
  output logic                 clearing,
  input  wire logic            iq_empty,
  input  wire hnbp_pkg::issue_t iq_head,
  output logic                 iq_pop,
  output logic                 empty,
  input  wire logic            pop,
  output hnbp_pkg::result_t    res_head
);
  import hnbp_pkg::*;

  localparam int RPTR_W = $clog2(RESULT_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_EXEC} state_t;

  state_t              state;
  logic [ENTRY_W-1:0]  mem [MAX_ORDER][TABLE_ENTRIES];
  logic [ENTRY_W-1:0]  rd_data [MAX_ORDER];
  logic [HASH_W-1:0]   clr_addr;
  issue_t              cur;
  logic [COUNT_W-1:0]  trained;
  logic                exec_done;
  logic                res_push;
  result_t             res_new;
  result_t             rq [RESULT_DEPTH];
  logic [RPTR_W-1:0]   rq_wr;
  logic [RPTR_W-1:0]   rq_rd;
  logic [RPTR_W:0]     rq_count;
  logic [ENTRY_W-1:0]  wr_data [MAX_ORDER];
  logic [18:0]         best_w;
  logic [18:0]         w;

  assign iq_pop    = (state == S_IDLE) && !clearing && !iq_empty;
  assign res_push  = (state == S_EXEC) && (cur.cmd == CMD_QUERY) &&
                     (rq_count != (RPTR_W+1)'(RESULT_DEPTH));
  assign exec_done = (state == S_EXEC) && ((cur.cmd != CMD_QUERY) || res_push);
  assign empty     = (rq_count == '0);
  assign res_head  = rq[rq_rd];

  // train update per bank
  always_comb begin
    for (int b = 0; b < MAX_ORDER; b++) begin
      if (rd_data[b][ENTRY_W-1:CONF_W] == cur.data_byte) begin
        wr_data[b] = (rd_data[b][CONF_W-1:0] == '1) ? rd_data[b] :
                     rd_data[b] + 1'b1;
      end else begin
        wr_data[b] = {cur.data_byte, CONF_W'(1)};
      end
    end
  end

  // query: best weighted order, lower order wins ties
  always_comb begin
    best_w                 = '0;
    w                      = '0;
    res_new.predicted_byte = '0;
    res_new.best_order     = (cur.fill != '0) ? ORDER_W'(1) : '0;
    for (int b = 0; b < MAX_ORDER; b++) begin
      w = 19'(rd_data[b][CONF_W-1:0]) * 19'(b + 1);
      if (ORDER_W'(b) < cur.fill && w > best_w) begin
        best_w                 = w;
        res_new.predicted_byte = rd_data[b][ENTRY_W-1:CONF_W];
        res_new.best_order     = ORDER_W'(b + 1);
      end
    end
    res_new.confidence    = (best_w > 19'd255) ? 8'd255 : best_w[7:0];
    res_new.trained_total = trained;
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < MAX_ORDER; b++) begin
      if (clearing) begin
        mem[b][clr_addr] <= '0;
      end else if (state == S_EXEC && cur.cmd == CMD_TRAIN &&
                   ORDER_W'(b) < cur.fill) begin
        mem[b][cur.hash[b]] <= wr_data[b];
      end
      if (iq_pop) begin
        rd_data[b] <= mem[b][iq_head.hash[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iq_pop) begin
      cur <= iq_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      clearing <= 1'b1;
      clr_addr <= '0;
      trained  <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (iq_pop) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_done) begin
            state <= S_IDLE;
            if (cur.cmd == CMD_TRAIN && trained != '1) begin
              trained <= trained + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq[rq_wr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= '0;
      rq_rd    <= '0;
      rq_count <= '0;
    end else begin
      if (res_push) begin
        rq_wr <= rq_wr + 1'b1;
      end
      if (pop && !empty) begin
        rq_rd <= rq_rd + 1'b1;
      end
      priority if (res_push && !(pop && !empty)) begin
        rq_count <= rq_count + 1'b1;
      end else if ((pop && !empty) && !res_push) begin
        rq_count <= rq_count - 1'b1;
      end
    end
  end

`include "hashed_ngram_byte_predictor_assert.svh"
  `HNBP_ASSERT_NOW(a_no_issue_while_clearing, clearing, !iq_pop)
  `HNBP_ASSERT_NEXT(a_pop_enters_exec, iq_pop, state == S_EXEC)
  `HNBP_ASSERT_NOW(a_result_queue_bound, 1'b1,
                   rq_count <= (RPTR_W+1)'(RESULT_DEPTH))
endmodule
`default_nettype wire

// ===== design/hashed_ngram_byte_predictor.sv =====
// top level of the hashed order-n context byte predictor
// usage:
//   input channel is a queue: drive cmd, data_byte, restart and raise push;
//   the item is taken at a clock edge with push high and full low.
//   cmd train updates every covered order table then shifts the byte into
//   history, cmd context only shifts, cmd query yields one result item.
//   result channel is a queue: while empty is low the oldest result sits on
//   predicted_byte, confidence, best_order, trained_total; pop takes it.
// timing:
//   the front keeps a running hash per order, stepped in the accept cycle,
//   and queues the item (four deep); the back works each item as a table
//   bank read, then the write back or the result, and pops no new item
//   before the last one is done.
// reset:
//   rst clears history and counters, then a clearing pass zeroes all table
//   rows, one row per cycle, with full held high until the pass ends.
// stall:
//   a stalled receiver fills the two-deep result queue, then the back and
//   the issue queue back up until full rises.
`default_nettype none
module hashed_ngram_byte_predictor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  data_byte,
  input  wire logic        restart,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       predicted_byte,
  output logic [7:0]       confidence,
  output logic [2:0]       best_order,
  output logic [30:0]      trained_total
);
  import hnbp_pkg::*;

  logic    clearing;
  logic    iq_pop;
  logic    iq_empty;
  issue_t  iq_head;
  result_t res_head;

  // front: history, hashes, issue queue
  hnbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .cmd       (cmd),
    .data_byte (data_byte),
    .restart   (restart),
    .full      (full),
    .clearing  (clearing),
    .iq_pop    (iq_pop),
    .iq_empty  (iq_empty),
    .iq_head   (iq_head)
  );

  // back: tables and result queue
  hnbp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .iq_empty (iq_empty),
    .iq_head  (iq_head),
    .iq_pop   (iq_pop),
    .empty    (empty),
    .pop      (pop),
    .res_head (res_head)
  );

  assign predicted_byte = res_head.predicted_byte;
  assign confidence     = res_head.confidence;
  assign best_order     = res_head.best_order;
  assign trained_total  = res_head.trained_total;
endmodule
`default_nettype wire

// ===== test/hnbp_checker.sv =====
// checker for the byte predictor: mirrors its tables, predicts queries and compares results
module hnbp_checker
  import hnbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  data_byte,
  input  wire logic        restart,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [7:0]  predicted_byte,
  input  wire logic [7:0]  confidence,
  input  wire logic [2:0]  best_order,
  input  wire logic [30:0] trained_total,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  pred_mem [MAX_ORDER][TABLE_ENTRIES];
  logic [15:0] conf_mem [MAX_ORDER][TABLE_ENTRIES];
  logic [HIST_W-1:0] hist;
  int unsigned       fill;
  logic [30:0]       trains;
  result_t           answers[$];

  function automatic logic [15:0] ctx_index(int unsigned ord);
    logic [31:0] h;
    h = FNV_BASIS;
    for (int k = ord; k > 0; k--) begin
      h = (h ^ {24'd0, hist[(k-1)*8 +: 8]}) * FNV_PRIME;
    end
    return h[15:0];
  endfunction

  initial begin
    foreach (pred_mem[o, e]) begin
      pred_mem[o][e] = '0;
      conf_mem[o][e] = '0;
    end
  end

  always @(posedge clk) begin
    logic [15:0] ix;
    result_t     r;
    int unsigned w, bw;
    if (rst) begin
      hist    = '0;
      fill    = 0;
      trains  = '0;
      errors  = 0;
      answers.delete();
    end else begin
      if (push && !full) begin
        if (restart) begin
          hist = '0;
          fill = 0;
        end
        if (cmd == CMD_TRAIN || cmd == CMD_CONTEXT) begin
          if (cmd == CMD_TRAIN) begin
            for (int o = 1; o <= fill; o++) begin
              ix = ctx_index(o);
              if (pred_mem[o-1][ix] == data_byte) begin
                if (conf_mem[o-1][ix] != 16'hffff) conf_mem[o-1][ix]++;
              end else begin
                pred_mem[o-1][ix] = data_byte;
                conf_mem[o-1][ix] = 16'd1;
              end
            end
            if (trains != 31'h7fffffff) trains = trains + 31'd1;
          end
          hist = {hist[HIST_W-9:0], data_byte};
          if (fill < MAX_ORDER) fill++;
        end else if (cmd == CMD_QUERY) begin
          r = '0;
          bw = 0;
          if (fill > 0) r.best_order = 3'd1;
          for (int o = 1; o <= fill; o++) begin
            ix = ctx_index(o);
            w = o * conf_mem[o-1][ix];
            if (w > bw) begin
              bw = w;
              r.predicted_byte = pred_mem[o-1][ix];
              r.best_order = 3'(o);
            end
          end
          r.confidence = (bw > 255) ? 8'd255 : bw[7:0];
          r.trained_total = trains;
          answers.push_back(r);
        end
      end
      if (pop && !empty) begin
        if (answers.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("%0t: result item with no query waiting", $realtime);
        end else begin
          r = answers.pop_front();
          if (r != {predicted_byte, confidence, best_order, trained_total}) begin
            errors = errors + 1;
            if (errors <= 10)
              $display({"%0t: mismatch exp byte %0d conf %0d ord %0d tot %0d, ",
                        "got %0d %0d %0d %0d"},
                       $realtime, r.predicted_byte, r.confidence, r.best_order,
                       r.trained_total, predicted_byte, confidence, best_order, trained_total);
          end
        end
      end
    end
    pending = answers.size();
  end
endmodule

// ===== test/testbench.sv =====
// stimulus and verdict for the hashed n-gram byte predictor
module testbench
  import hnbp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [1:0]  cmd = CMD_TRAIN;
  logic [7:0]  data_byte = '0;
  logic        restart = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty;
  logic [7:0]  predicted_byte, confidence;
  logic [2:0]  best_order;
  logic [30:0] trained_total;
  int          errors, pending;
  int          cycles = 0;
  bit          hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hashed_ngram_byte_predictor i_dut (.*);
  hnbp_checker i_chk (.*);

  // a run well past reset clear plus the whole stimulus at worst-case gaps and stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("** hashed_ngram_byte_predictor: FAILED **");
      $finish;
    end
  end

  // offer one item, then hold it until taken; gap drawn per item
  task automatic send(logic [1:0] c, logic [7:0] b, logic rs, bit gap = 1'b1);
    int idle;
    idle = gap ? $urandom_range(17, 0) : 0;
    if (idle > 0) begin
      push <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    push      <= 1'b1;
    cmd       <= c;
    data_byte <= b;
    restart   <= rs;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // train a repeating phrase so higher orders build confidence
  task automatic phrase_run(int reps);
    logic [7:0] words[8];
    int len;
    len = $urandom_range(8, 2);
    foreach (words[i]) words[i] = 8'($urandom);
    send(CMD_TRAIN, words[0], 1'b1);
    for (int r = 0; r < reps; r++) begin
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(3, 0) == 0) send(CMD_QUERY, 8'($urandom), 1'b0);
        send(($urandom_range(9, 0) == 0) ? CMD_CONTEXT : CMD_TRAIN,
             ($urandom_range(19, 0) == 0) ? 8'($urandom) : words[i], 1'b0);
      end
    end
  endtask

  // receiver: random stalls per item, plus a long hold-off when asked
  initial begin
    int idle;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        pop <= 1'b0;
      end else if (pop && !empty) begin
        idle = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(17, 0);
        if (idle > 0) begin
          pop <= 1'b0;
          repeat (idle) @(posedge clk);
        end
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int sent;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: empty history, all-zero weights, extremes, unused cmd
    send(CMD_QUERY, 8'hff, 1'b0);
    send(CMD_CONTEXT, 8'h00, 1'b0);
    send(CMD_QUERY, 8'h00, 1'b0);
    send(CMD_TRAIN, 8'hff, 1'b0);
    send(CMD_TRAIN, 8'h00, 1'b0);
    send(CMD_TRAIN, 8'hff, 1'b0);
    send(CMD_TRAIN, 8'h00, 1'b0);
    send(CMD_CONTEXT, 8'hff, 1'b0);
    send(CMD_QUERY, 8'h55, 1'b0);
    send(CMD_UNUSED, 8'haa, 1'b1);
    send(CMD_QUERY, 8'h00, 1'b0);
    send(CMD_UNUSED, 8'h55, 1'b0);
    for (int i = 0; i < 8; i++) send(CMD_TRAIN, 8'h5a, 1'b0, 1'b0);
    send(CMD_QUERY, 8'h00, 1'b0, 1'b0);
    send(CMD_TRAIN, 8'ha5, 1'b1, 1'b0);
    send(CMD_QUERY, 8'h00, 1'b0, 1'b0);
    // sender pauses until every expected result is back
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // long receiver hold-off while items keep coming, block must fill
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 30; i++) send(CMD_QUERY, 8'h00, 1'b0, 1'b0);
    join
    sent = 50;
    while (sent < 1400) begin
      if ($urandom_range(4, 0) != 0) begin
        phrase_run($urandom_range(12, 3));
        sent += 40;
      end else begin
        // noise, including unused commands and restarts
        for (int i = 0; i < 20; i++)
          send(2'($urandom), 8'($urandom), ($urandom_range(7, 0) == 0));
        sent += 20;
      end
    end
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** hashed_ngram_byte_predictor: PASSED **");
    end else begin
      $display("** hashed_ngram_byte_predictor: FAILED **");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/hnbp_pkg.sv
design/hnbp_front.sv
design/hnbp_back.sv
design/hashed_ngram_byte_predictor.sv
test/hnbp_checker.sv
test/testbench.sv
